FILE: hdl/eqds_pkg.sv
// eqds_pkg: beat types, command and status codes for the event queue core
// no dependencies; imported by eqds_cell, event_queue_with_delayed_slots_core and the bench
`timescale 1ns / 1ps

package eqds_pkg;

   localparam logic [2:0] CMD_POST     = 3'd0;
   localparam logic [2:0] CMD_REPLACE  = 3'd1;
   localparam logic [2:0] CMD_DELAYED  = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_POLL     = 3'd4;
   localparam logic [2:0] CMD_SET_TICK = 3'd5;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_PARAM = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] event_id;
      logic [31:0] event_param;
      logic [31:0] delay_ticks;
      logic [31:0] new_tick;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        got_event;
      logic [15:0] out_event_id;
      logic [31:0] out_param;
      logic        out_in_range;
      logic [31:0] dropped_total;
      logic [4:0]  queue_level;
      logic [31:0] tick_now;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic wr_id;
      logic wr_param;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hdl/eqds_cell.sv
// eqds_cell: one queue entry (event id and tag) in the row of cells
// depends on eqds_pkg
`timescale 1ns / 1ps

module eqds_cell (
   input  logic                  clock,
   input  eqds_pkg::cell_ctl_type ctl,
   input  logic [15:0]           wr_id,
   input  logic [31:0]           wr_param,
   input  logic [15:0]           nxt_id,
   input  logic [31:0]           nxt_param,
   output logic [15:0]           id,
   output logic [31:0]           param
);
   import eqds_pkg::*;

   logic [15:0] id_ff;
   logic [15:0] id_in;
   logic [31:0] param_ff;
   logic [31:0] param_in;

   // shift toward the head on pop, otherwise take a write or hold
   always_comb begin
      id_in    = id_ff;
      param_in = param_ff;
      if (ctl.shift) begin
         id_in    = nxt_id;
         param_in = nxt_param;
      end else begin
         if (ctl.wr_id) begin
            id_in = wr_id;
         end
         if (ctl.wr_param) begin
            param_in = wr_param;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      param_ff <= param_in;
   end

   assign id    = id_ff;
   assign param = param_ff;

endmodule

FILE: hdl/event_queue_with_delayed_slots_core.sv
// event_queue_with_delayed_slots_core: coalescing event fifo with delayed-post slots
// depends on eqds_pkg and eqds_cell
//
//   port group   dir   role
//   req_*        in    command beat (valid / stall)
//   rsp_*        out   one result beat per command (valid / stall)
//   csr_*        in    event_count register write
//
// one command at a time: accept, execute, then result register load
// post, tick, set_tick, post_delayed: S_EXEC, then S_FINISH loads the result
// post_replace: on a non-empty queue S_SEARCH walks the cells newest first, then S_FINISH
// poll: S_FIRE scans the slots (one slot per cycle), then S_POP, then S_FINISH
// reset is synchronous, clears control state; queue and slot payloads stay unknown
// req_stall is high while a command is in flight or its result cannot be loaded
`timescale 1ns / 1ps

module event_queue_with_delayed_slots_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int DELAY_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eqds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eqds_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import eqds_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SLOT_W = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_FIRE   = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   // sequencer and command latch
   logic [2:0]        state_ff, state_in;
   req_type           cmd_ff;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [SLOT_W-1:0] s_ff, s_in;

   // architectural state
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       tick_ff, tick_in;
   logic [31:0]       drop_ff, drop_in;
   logic [15:0]       event_count_ff;
   logic [DELAY_SLOTS-1:0] used_ff, used_in;
   logic [31:0]       slot_due   [DELAY_SLOTS];
   logic [15:0]       slot_id    [DELAY_SLOTS];
   logic [31:0]       slot_param [DELAY_SLOTS];

   // per-command result fields
   logic [1:0]  status_ff, status_in;
   logic        got_ff, got_in;
   logic [15:0] oid_ff, oid_in;
   logic [31:0] oparam_ff, oparam_in;
   logic        inr_ff, inr_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // cell row
   logic [15:0]  cell_id    [QUEUE_DEPTH];
   logic [31:0]  cell_param [QUEUE_DEPTH];
   cell_ctl_type cell_ctl   [QUEUE_DEPTH];

   // cell write bus
   logic             app_req, app_en;
   logic [15:0]      app_id;
   logic [31:0]      app_param;
   logic             rep_en;
   logic [IDX_W-1:0] rep_idx;
   logic             shift_en;
   logic [IDX_W-1:0] app_idx;

   // slot write
   logic              slot_wr_en;
   logic [SLOT_W-1:0] free_idx;
   logic              free_any;
   logic [31:0]       due_diff;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = DELAY_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_any = 1'b1;
         end
      end
   end

   // wrap-safe due test for the scanned slot
   assign due_diff = tick_ff - slot_due[s_ff];
   assign app_idx  = fill_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      fill_in      = fill_ff;
      tick_in      = tick_ff;
      drop_in      = drop_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      got_in       = got_ff;
      oid_in       = oid_ff;
      oparam_in    = oparam_ff;
      inr_in       = inr_ff;
      app_req      = 1'b0;
      app_en       = 1'b0;
      app_id       = cmd_ff.event_id;
      app_param    = cmd_ff.event_param;
      rep_en       = 1'b0;
      rep_idx      = k_ff;
      shift_en     = 1'b0;
      slot_wr_en   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STAT_OK;
            got_in    = 1'b0;
            oid_in    = '0;
            oparam_in = '0;
            inr_in    = 1'b0;
            state_in  = S_FINISH;
            case (cmd_ff.cmd)
               CMD_POST: begin
                  app_req = 1'b1;
               end
               CMD_REPLACE: begin
                  if (fill_ff == '0) begin
                     app_req = 1'b1;
                  end else begin
                     k_in     = IDX_W'(fill_ff - 1'b1);
                     state_in = S_SEARCH;
                  end
               end
               CMD_DELAYED: begin
                  if (cmd_ff.delay_ticks[31]) begin
                     status_in = STAT_PARAM;
                  end else if (free_any) begin
                     slot_wr_en        = 1'b1;
                     used_in[free_idx] = 1'b1;
                  end else begin
                     drop_in   = drop_ff + 32'd1;
                     status_in = STAT_FULL;
                  end
               end
               CMD_TICK: begin
                  tick_in = tick_ff + 32'd1;
               end
               CMD_POLL: begin
                  s_in     = '0;
                  state_in = S_FIRE;
               end
               CMD_SET_TICK: begin
                  tick_in = cmd_ff.new_tick;
               end
               default: begin
                  status_in = STAT_PARAM;
               end
            endcase
         end
         S_SEARCH: begin
            // newest entry first
            if (cell_id[k_ff] == cmd_ff.event_id) begin
               rep_en   = 1'b1;
               state_in = S_FINISH;
            end else if (k_ff == '0) begin
               app_req  = 1'b1;
               state_in = S_FINISH;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_FIRE: begin
            if (used_ff[s_ff] && !due_diff[31]) begin
               used_in[s_ff] = 1'b0;
               app_req       = 1'b1;
               app_id        = slot_id[s_ff];
               app_param     = slot_param[s_ff];
            end
            if (s_ff == SLOT_W'(DELAY_SLOTS - 1)) begin
               state_in = S_POP;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         S_POP: begin
            state_in = S_FINISH;
            if (fill_ff == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               shift_en  = 1'b1;
               fill_in   = fill_ff - 1'b1;
               got_in    = 1'b1;
               oid_in    = cell_id[0];
               oparam_in = cell_param[0];
               inr_in    = cell_id[0] < event_count_ff;
               status_in = STAT_OK;
               if (!(cell_id[0] < event_count_ff)) begin
                  drop_in = drop_ff + 32'd1;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = status_ff;
               rsp_data_in.got_event     = got_ff;
               rsp_data_in.out_event_id  = oid_ff;
               rsp_data_in.out_param     = oparam_ff;
               rsp_data_in.out_in_range  = inr_ff;
               rsp_data_in.dropped_total = drop_ff;
               rsp_data_in.queue_level   = 5'(fill_ff);
               rsp_data_in.tick_now      = tick_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // shared append: drop when full
      if (app_req) begin
         if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
            drop_in   = drop_ff + 32'd1;
            status_in = STAT_FULL;
         end else begin
            app_en  = 1'b1;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // cell controls and the row itself
   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic [15:0] nxt_id;
         logic [31:0] nxt_param;

         assign cell_ctl[gi].wr_id    = app_en && (app_idx == IDX_W'(gi));
         assign cell_ctl[gi].wr_param = (app_en && (app_idx == IDX_W'(gi)))
                                        || (rep_en && (rep_idx == IDX_W'(gi)));
         assign cell_ctl[gi].shift    = shift_en;

         if (gi < QUEUE_DEPTH - 1) begin : g_mid
            assign nxt_id    = cell_id[gi + 1];
            assign nxt_param = cell_param[gi + 1];
         end else begin : g_last
            assign nxt_id    = app_id;
            assign nxt_param = app_param;
         end

         eqds_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[gi]),
            .wr_id     (app_id),
            .wr_param  (app_param),
            .nxt_id    (nxt_id),
            .nxt_param (nxt_param),
            .id        (cell_id[gi]),
            .param     (cell_param[gi])
         );
      end
   endgenerate

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         tick_ff        <= '0;
         drop_ff        <= '0;
         used_ff        <= '0;
         event_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         drop_ff      <= drop_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            event_count_ff <= csr_wr_data;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      s_ff        <= s_in;
      status_ff   <= status_in;
      got_ff      <= got_in;
      oid_ff      <= oid_in;
      oparam_ff   <= oparam_in;
      inr_ff      <= inr_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_data;
      end
      if (slot_wr_en) begin
         slot_due[free_idx]   <= tick_ff + cmd_ff.delay_ticks;
         slot_id[free_idx]    <= cmd_ff.event_id;
         slot_param[free_idx] <= cmd_ff.event_param;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed");

   a_search_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (FILL_W'(k_ff) < fill_ff))
      else $error("replace walk outside queued entries");

   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && fill_ff != '0) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("pop did not lower fill");
`endif

endmodule

FILE: tb/tb_event_queue_with_delayed_slots_core.sv
// tb_event_queue_with_delayed_slots_core: self-checking bench for the event queue core
// depends on eqds_pkg and event_queue_with_delayed_slots_core; predicts every result beat
`timescale 1ns / 1ps

module tb_event_queue_with_delayed_slots_core;
   import eqds_pkg::*;

   localparam int QDEPTH = 16;
   localparam int NSLOTS = 8;
   localparam logic [31:0] DELAY_MAX = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   event_queue_with_delayed_slots_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, mirrors the core
   logic [15:0] q_id [QDEPTH];
   logic [31:0] q_tag [QDEPTH];
   int unsigned q_head, q_fill;
   logic [31:0] ticks, drops;
   logic        s_busy [NSLOTS];
   logic [31:0] s_due [NSLOTS];
   logic [15:0] s_id [NSLOTS];
   logic [31:0] s_tag [NSLOTS];
   logic [15:0] id_limit;

   rsp_type expected_rsps[$];
   int  errors = 0;
   bit  rsp_hold = 1'b0;   // long receiver hold-off in progress

   function automatic logic [1:0] q_push(logic [15:0] id, logic [31:0] tag);
      if (q_fill >= QDEPTH) begin
         drops++;
         return STAT_FULL;
      end
      q_id[(q_head + q_fill) % QDEPTH] = id;
      q_tag[(q_head + q_fill) % QDEPTH] = tag;
      q_fill++;
      return STAT_OK;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type o;
      int p;
      int k;
      o = '0;
      o.status = STAT_OK;
      case (r.cmd)
         CMD_POST: begin
            o.status = q_push(r.event_id, r.event_param);
         end
         CMD_REPLACE: begin
            // newest matching entry wins
            p = -1;
            for (k = int'(q_fill) - 1; k >= 0 && p < 0; k--)
               if (q_id[(q_head + k) % QDEPTH] == r.event_id) p = (q_head + k) % QDEPTH;
            if (p >= 0) q_tag[p] = r.event_param;
            else o.status = q_push(r.event_id, r.event_param);
         end
         CMD_DELAYED: begin
            if (r.delay_ticks >= DELAY_MAX) begin
               o.status = STAT_PARAM;
            end else begin
               p = -1;
               for (k = 0; k < NSLOTS && p < 0; k++)
                  if (!s_busy[k]) p = k;
               if (p < 0) begin
                  drops++;
                  o.status = STAT_FULL;
               end else begin
                  s_busy[p] = 1'b1;
                  s_due[p] = ticks + r.delay_ticks;
                  s_id[p] = r.event_id;
                  s_tag[p] = r.event_param;
               end
            end
         end
         CMD_TICK: ticks++;
         CMD_POLL: begin
            // wrap-safe due test, slots fire in index order
            for (k = 0; k < NSLOTS; k++) begin
               logic [31:0] diff;
               diff = ticks - s_due[k];
               if (s_busy[k] && !diff[31]) begin
                  s_busy[k] = 1'b0;
                  void'(q_push(s_id[k], s_tag[k]));
               end
            end
            if (q_fill == 0) begin
               o.status = STAT_EMPTY;
            end else begin
               o.got_event = 1'b1;
               o.out_event_id = q_id[q_head];
               o.out_param = q_tag[q_head];
               o.out_in_range = q_id[q_head] < id_limit;
               if (!o.out_in_range) drops++;
               q_head = (q_head + 1) % QDEPTH;
               q_fill--;
            end
         end
         CMD_SET_TICK: ticks = r.new_tick;
         default: o.status = STAT_PARAM;
      endcase
      o.dropped_total = drops;
      o.queue_level = q_fill[4:0];
      o.tick_now = ticks;
      return o;
   endfunction

   // one command beat, with a random lead-in gap
   task automatic send_cmd(req_type r, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0);
      repeat (gap) @(negedge clock);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(predict_result(r));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic req_type mk(logic [2:0] c, logic [15:0] id = 0, logic [31:0] tag = 0,
                                  logic [31:0] dly = 0, logic [31:0] nt = 0);
      req_type r;
      r.cmd = c; r.event_id = id; r.event_param = tag;
      r.delay_ticks = dly; r.new_tick = nt;
      return r;
   endfunction

   task automatic drain();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_count(logic [15:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      id_limit = v;
   endtask

   // checker: compares each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e.status !== rsp_data.status)
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
            if (e.got_event !== rsp_data.got_event)
               $display("%0t: got_event exp %0d got %0d", $time, e.got_event, rsp_data.got_event);
            if (e.out_event_id !== rsp_data.out_event_id)
               $display("%0t: out_event_id exp %h got %h", $time, e.out_event_id,
                        rsp_data.out_event_id);
            if (e.out_param !== rsp_data.out_param)
               $display("%0t: out_param exp %h got %h", $time, e.out_param, rsp_data.out_param);
            if (e.out_in_range !== rsp_data.out_in_range)
               $display("%0t: out_in_range exp %0d got %0d", $time, e.out_in_range,
                        rsp_data.out_in_range);
            if (e.dropped_total !== rsp_data.dropped_total)
               $display("%0t: dropped_total exp %h got %h", $time, e.dropped_total,
                        rsp_data.dropped_total);
            if (e.queue_level !== rsp_data.queue_level)
               $display("%0t: queue_level exp %0d got %0d", $time, e.queue_level,
                        rsp_data.queue_level);
            if (e.tick_now !== rsp_data.tick_now)
               $display("%0t: tick_now exp %h got %h", $time, e.tick_now, rsp_data.tick_now);
            if (e !== rsp_data) errors++;
         end
      end
   end

   // receiver stall pattern: random per beat, long hold-off on request
   initial begin
      int w;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_hold = 1'b0;
         end
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge rsp_valid or negedge rsp_valid or posedge clock);
         end
         if (w > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // edge cases: empty poll, bad codes, delay limit, ticks and id extremes
   task automatic test_directed();
      send_cmd(mk(CMD_POLL));
      send_cmd(mk(3'd6));
      send_cmd(mk(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_cmd(mk(CMD_DELAYED, 16'h1, 32'h1, DELAY_MAX));
      send_cmd(mk(CMD_DELAYED, 16'h2, 32'h2, 32'hFFFF_FFFF));
      send_cmd(mk(CMD_SET_TICK, 0, 0, 0, 32'hFFFF_FFFE));
      send_cmd(mk(CMD_DELAYED, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      send_cmd(mk(CMD_DELAYED, 16'h0, 32'h0, 32'h3));
      send_cmd(mk(CMD_TICK));
      send_cmd(mk(CMD_TICK));
      send_cmd(mk(CMD_POST, 16'hFFFF, 32'hA5A5_5A5A));
      send_cmd(mk(CMD_REPLACE, 16'hFFFF, 32'h1234_5678));
      send_cmd(mk(CMD_REPLACE, 16'h0000, 32'hFFFF_FFFF));
      send_cmd(mk(CMD_POLL));
      send_cmd(mk(CMD_TICK));
      send_cmd(mk(CMD_POLL));
      send_cmd(mk(CMD_POLL));
      send_cmd(mk(CMD_POLL));
      send_cmd(mk(CMD_POLL));
   endtask

   // fill queue and slots past capacity, then fire due slots into a full queue
   task automatic test_overflow();
      int k;
      for (k = 0; k < NSLOTS + 2; k++)
         send_cmd(mk(CMD_DELAYED, 16'(k), $urandom, 32'(k % 3)));
      for (k = 0; k < QDEPTH + 3; k++)
         send_cmd(mk(k[0] ? CMD_REPLACE : CMD_POST, 16'(k + 100), $urandom));
      send_cmd(mk(CMD_TICK));
      send_cmd(mk(CMD_TICK));
      for (k = 0; k < QDEPTH + NSLOTS + 2; k++) send_cmd(mk(CMD_POLL));
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_backpressure();
      int k;
      drain();
      rsp_hold = 1'b1;
      for (k = 0; k < 40; k++)
         send_cmd(mk(3'($urandom_range(0, 5)), 16'($urandom_range(0, 7)), $urandom,
                     $urandom_range(0, 4)), 1'b1);
      drain();
   endtask

   function automatic req_type rand_cmd();
      req_type r;
      int sel;
      sel = $urandom_range(0, 99);
      r.event_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      r.event_param = $urandom;
      r.delay_ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
      r.new_tick = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFF0 + $urandom_range(0, 31);
      if (sel < 22) r.cmd = CMD_POST;
      else if (sel < 40) r.cmd = CMD_REPLACE;
      else if (sel < 55) r.cmd = CMD_DELAYED;
      else if (sel < 67) r.cmd = CMD_TICK;
      else if (sel < 95) r.cmd = CMD_POLL;
      else if (sel < 98) r.cmd = CMD_SET_TICK;
      else r.cmd = 3'($urandom_range(6, 7));
      return r;
   endfunction

   task automatic test_random(int n);
      int k;
      for (k = 0; k < n; k++) send_cmd(rand_cmd());
   endtask

   initial begin
      q_head = 0; q_fill = 0; ticks = 0; drops = 0; id_limit = 0;
      for (int k = 0; k < NSLOTS; k++) s_busy[k] = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      write_count(16'hFFFF);
      test_directed();
      write_count(16'd8);
      test_overflow();
      test_backpressure();
      write_count(16'd0);
      test_random(300);
      write_count(16'd12);
      test_random(300);
      write_count(16'hFFFF);
      test_random(300);
      write_count(16'd6);
      test_random(300);
      drain();
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
